>>> rtl/nbt_pkg.sv
// Shared constants and types for the nth-brightest threshold block.
// No dependencies; compile first.
package nbt_pkg;

    localparam int NUM_BINS             = 256;
    localparam int BIN_W                = 8;
    localparam int RANK_W               = 23;
    localparam int MAX_PIXELS_LOG2_DEF  = 22;

    typedef enum logic [1:0] {
        ST_CLEAR,   // clearing sweep after reset
        ST_COUNT,   // histogram accumulation
        ST_DRAIN,   // last write lands, output slot frees
        ST_WALK     // search from bin 255 down, zeroing bins
    } t_state;

endpackage

>>> rtl/nbt_pix_if.sv
// Pixel input channel: valid/ready handshake with pixel and end-of-frame flag.
// Depends on nbt_pkg for field widths.
interface nbt_pix_if;
    import nbt_pkg::*;

    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] pixel_value;
    logic             last_pixel;

    modport source (output valid, output pixel_value, output last_pixel, input ready);
    modport sink   (input valid, input pixel_value, input last_pixel, output ready);
endinterface

>>> rtl/nbt_thr_if.sv
// Threshold result channel: valid/ready handshake with threshold level.
// Depends on nbt_pkg for field widths.
interface nbt_thr_if;
    import nbt_pkg::*;

    logic             valid;
    logic             ready;
    logic [BIN_W-1:0] threshold_level;

    modport source (output valid, output threshold_level, input ready);
    modport sink   (input valid, input threshold_level, output ready);
endinterface

>>> rtl/nth_brightest_threshold_top.sv
// Percentile threshold: counts one frame of 8-bit pixels into a 256-bin
// histogram held in a RAM, then walks the bins from 255 down, subtracting
// each count from the configured rank, and reports the level just below the
// bin where the rank ran out (0 if never, 255 for rank 0). Pixels are taken
// one per cycle, back to back, through a read-modify-write on the RAM with a
// one-entry forward for repeated bins. After the last pixel i_pix.ready stays
// low through the drain, while the last count write lands, and through the
// walk: 256 RAM reads from bin 255 down, then the data of bin 0 is applied.
// The result becomes valid as the walk ends. The walk zeroes every bin, so
// the next frame starts clean. After reset a clearing sweep zeroes all 256
// bins with i_pix.ready low. The result sits in an output register; the next
// frame may stream in while it waits, but that frame's walk holds in drain
// until the waiting result is taken.
// Each bin saturates at 2^MAX_PIXELS_LOG2. Write rank only while idle.
// Depends on nbt_pkg, nbt_pix_if, nbt_thr_if, nbt_ram.
module nth_brightest_threshold_top #(
    parameter int MAX_PIXELS_LOG2 = nbt_pkg::MAX_PIXELS_LOG2_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [nbt_pkg::RANK_W-1:0]  i_cfg_wdata,
    nbt_pix_if.sink                     i_pix,
    nbt_thr_if.source                   o_thr
);
    import nbt_pkg::*;

    // count holds 0 .. 2^MAX_PIXELS_LOG2
    localparam int CNT_W = MAX_PIXELS_LOG2 + 1;
    // signed remainder: positive rank minus one full bin never overflows
    localparam int REM_W = ((RANK_W > CNT_W) ? RANK_W : CNT_W) + 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(1) << MAX_PIXELS_LOG2;
    localparam logic [BIN_W-1:0] LVL_TOP   = {BIN_W{1'b1}};

    t_state r_state, n_state;

    logic [RANK_W-1:0] r_rank;

    // sweep / walk read counter; bit BIN_W marks all reads issued
    logic [BIN_W:0]    r_cnt;

    // counting pipeline: read issued, data next cycle
    logic              r_s1_valid;
    logic [BIN_W-1:0]  r_s1_addr;
    // forward of the previous cycle's write
    logic              r_fw_valid;
    logic [BIN_W-1:0]  r_fw_addr;
    logic [CNT_W-1:0]  r_fw_data;

    // walk data stage
    logic              r_w1_valid;
    logic [BIN_W-1:0]  r_w1_addr;
    logic [REM_W-1:0]  r_rem;
    logic [BIN_W-1:0]  r_level;

    logic              r_out_valid;
    logic [BIN_W-1:0]  r_out_level;

    // FSM outputs
    logic              in_ready;
    logic              walk_rd;
    logic              clr_we;

    logic              pix_acc;
    logic              out_take;
    logic              walk_end;

    // RAM ports
    logic              ram_we;
    logic [BIN_W-1:0]  ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [BIN_W-1:0]  ram_raddr;
    logic [CNT_W-1:0]  ram_rdata;

    logic [CNT_W-1:0]  cnt_cur;
    logic [CNT_W-1:0]  cnt_inc;
    logic              take;
    logic [REM_W-1:0]  n_rem;
    logic [BIN_W-1:0]  n_level;

    assign pix_acc  = i_pix.valid && in_ready;
    assign out_take = r_out_valid && o_thr.ready;
    assign walk_end = r_w1_valid && (r_w1_addr == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_cnt[BIN_W-1:0] == LVL_TOP) begin
                    n_state = ST_COUNT;
                end
            end
            ST_COUNT: begin
                if (pix_acc && i_pix.last_pixel) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last count write done and result slot free
                if (!r_s1_valid && !r_out_valid) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (walk_end) begin
                    n_state = ST_COUNT;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready = 1'b0;
        walk_rd  = 1'b0;
        clr_we   = 1'b0;
        case (r_state)
            ST_CLEAR: clr_we   = 1'b1;
            ST_COUNT: in_ready = 1'b1;
            ST_DRAIN: in_ready = 1'b0;
            ST_WALK:  walk_rd  = !r_cnt[BIN_W];
            default:  in_ready = 1'b0;
        endcase
    end

    assign i_pix.ready = in_ready;

    // counting: saturating increment with forward from last write
    assign cnt_cur = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : ram_rdata;
    assign cnt_inc = (cnt_cur < CNT_LIMIT) ? cnt_cur + CNT_W'(1) : cnt_cur;

    // walk: take the bin while the rank is still positive
    assign take    = !r_rem[REM_W-1] && (r_rem != '0);
    assign n_rem   = take ? r_rem - REM_W'(ram_rdata) : r_rem;
    assign n_level = take ? ((r_w1_addr == '0) ? '0 : r_w1_addr - BIN_W'(1)) : r_level;

    // single write port: sweep, count write-back, walk zeroing are exclusive
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_s1_addr;
        ram_wdata = '0;
        if (clr_we) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt[BIN_W-1:0];
        end else if (r_s1_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_s1_addr;
            ram_wdata = cnt_inc;
        end else if (r_w1_valid) begin
            ram_we    = 1'b1;
            ram_waddr = r_w1_addr;
        end
    end

    assign ram_raddr = walk_rd ? ~r_cnt[BIN_W-1:0] : i_pix.pixel_value;

    nbt_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rank      <= '0;
            r_cnt       <= '0;
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_w1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_rank <= i_cfg_wdata;
            end
            if (clr_we || walk_rd) begin
                r_cnt <= r_cnt + (BIN_W+1)'(1);
            end else if (r_state == ST_DRAIN) begin
                r_cnt <= '0;
            end
            r_s1_valid <= pix_acc;
            r_fw_valid <= r_s1_valid;
            r_w1_valid <= walk_rd;
            if (walk_end) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_s1_addr <= i_pix.pixel_value;
        r_fw_addr <= r_s1_addr;
        r_fw_data <= cnt_inc;
        r_w1_addr <= ~r_cnt[BIN_W-1:0];
        if (r_state == ST_DRAIN) begin
            r_rem   <= REM_W'(r_rank);
            r_level <= LVL_TOP;
        end else if (r_w1_valid) begin
            r_rem   <= n_rem;
            r_level <= n_level;
        end
        if (walk_end) begin
            r_out_level <= n_level;
        end
    end

    assign o_thr.valid           = r_out_valid;
    assign o_thr.threshold_level = r_out_level;

endmodule

>>> rtl/nbt_ram.sv
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module nbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> tb/sv/nbt_threshold_sb_pkg.sv
// Scoreboard class for the nth-brightest threshold testbench: histogram
// predictor plus an in-order queue of expected threshold levels.
// Depends on nbt_pkg (RTL) for widths and bin count.
`timescale 1ns / 100ps

package nbt_threshold_sb_pkg;
    import nbt_pkg::*;

    class threshold_scoreboard;
        longint unsigned     bin_count [NUM_BINS];
        logic [RANK_W-1:0]   rank;
        logic [RANK_W:0]     rank_left;     // leftover rank after last search, kept only
        logic [BIN_W-1:0]    pending_levels [$];
        int unsigned         n_errors;
        int unsigned         n_pixels;
        int unsigned         n_frames;
        int unsigned         n_levels;
        int unsigned         n_ranks;

        function void set_rank(logic [RANK_W-1:0] value);
            rank = value;
            n_ranks++;
        endfunction

        // Count one accepted pixel; on the last pixel, walk the bins and queue
        // the threshold the block should report, then clear the histogram.
        function void count_pixel(logic [BIN_W-1:0] pv, logic lp);
            longint rem;
            int     lvl;
            n_pixels++;
            if (bin_count[pv] < (64'd1 << MAX_PIXELS_LOG2_DEF))
                bin_count[pv]++;
            if (!lp)
                return;
            rem = longint'(rank);
            lvl = NUM_BINS - 1;
            while (lvl >= 0 && rem > 0) begin
                rem -= longint'(bin_count[lvl]);
                lvl--;
            end
            rank_left = rem[RANK_W:0];
            if (lvl < 0)
                lvl = 0;
            pending_levels = {pending_levels, lvl[BIN_W-1:0]};
            foreach (bin_count[i])
                bin_count[i] = 0;
            n_frames++;
        endfunction

        function void check_level(logic [BIN_W-1:0] got);
            logic [BIN_W-1:0] want;
            n_levels++;
            if (pending_levels.size() == 0) begin
                n_errors++;
                $display("%0t: threshold_level expected none, actual %0d", $time, got);
                return;
            end
            want = pending_levels.pop_front();
            if (got !== want) begin
                n_errors++;
                $display("%0t: threshold_level expected %0d, actual %0d", $time, want, got);
            end
        endfunction
    endclass

endpackage

>>> tb/sv/nth_brightest_threshold_top_tb.sv
// Testbench for nth_brightest_threshold_top: streams pixel frames, checks
// each threshold against the scoreboard's histogram walk.
// Depends on nbt_pkg, nbt_pix_if, nbt_thr_if, nbt_threshold_sb_pkg and the RTL.
`timescale 1ns / 100ps

module nth_brightest_threshold_top_tb;
    import nbt_pkg::*;
    import nbt_threshold_sb_pkg::*;

    // Largest rank the work range allows (2^22).
    localparam logic [RANK_W-1:0] RANK_MAX = 23'd4194304;
    // Longest legal quiet stretch is the post-reset clear or one bin walk
    // plus receiver stalls; this is many times that.
    localparam int                IDLE_LIMIT = 5000;
    localparam int                ITEMS_PER_MIX = 233;

    typedef enum int {
        SPREAD_UNIFORM,     // whole 0..255 range
        SPREAD_BRIGHT,      // upper quarter only
        SPREAD_NARROW,      // a handful of neighboring bins, lots of repeats
        SPREAD_FLAT         // every pixel in one bin
    } t_spread;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [RANK_W-1:0]   i_cfg_wdata;

    nbt_pix_if pix_if ();
    nbt_thr_if thr_if ();

    threshold_scoreboard sb;

    int src_idle_pct;
    int dst_idle_pct;
    int n_sent;
    int quiet_cycles;

    nth_brightest_threshold_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_if),
        .o_thr       (thr_if)
    );

    // 12 ns clock
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Everything the TB drives is known from time 0.
    initial begin
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_wdata        = '0;
        pix_if.valid       = 1'b0;
        pix_if.pixel_value = '0;
        pix_if.last_pixel  = 1'b0;
        thr_if.ready       = 1'b0;
        src_idle_pct       = 0;
        dst_idle_pct       = 0;
        n_sent             = 0;
        quiet_cycles       = 0;
        sb                 = new;
    end

    // Result sink: ready toggles at the falling edge per the current mix,
    // every result transaction is checked at the rising edge.
    always @(negedge i_clk) begin
        thr_if.ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && thr_if.valid && thr_if.ready)
            sb.check_level(thr_if.threshold_level);
    end

    // Watchdog: any transaction on either channel restarts the count.
    always @(posedge i_clk) begin
        if ((pix_if.valid && pix_if.ready) || (thr_if.valid && thr_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog, no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // One pixel transaction. Entered and left at a falling edge. Random
    // source gaps go in front; valid stays high into the next call when
    // no gap is drawn, so back-to-back streaming happens naturally.
    task automatic send_pixel(input logic [BIN_W-1:0] pv, input logic lp);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_if.valid       <= 1'b1;
        pix_if.pixel_value <= pv;
        pix_if.last_pixel  <= lp;
        @(posedge i_clk);
        while (!pix_if.ready)
            @(posedge i_clk);
        sb.count_pixel(pv, lp);
        n_sent++;
        @(negedge i_clk);
    endtask

    // Hold off the source until every queued threshold has been seen, then
    // add an idle margin so a rank write lands on an idle block.
    task automatic wait_levels_done();
        pix_if.valid <= 1'b0;
        while (sb.pending_levels.size() != 0)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // Single-cycle rank write; only called with no frame in flight.
    task automatic write_rank(input logic [RANK_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_rank(value);
    endtask

    task automatic send_frame(input int len, input t_spread spread);
        logic [BIN_W-1:0] base;
        logic [BIN_W-1:0] pv;
        base = BIN_W'($urandom_range(255));
        for (int k = 0; k < len; k++) begin
            case (spread)
                SPREAD_BRIGHT: pv = BIN_W'($urandom_range(255, 192));
                SPREAD_NARROW: pv = base ^ BIN_W'($urandom_range(3));
                SPREAD_FLAT:   pv = base;
                default:       pv = BIN_W'($urandom_range(255));
            endcase
            send_pixel(pv, k == len - 1);
        end
    endtask

    initial begin
        logic [RANK_W-1:0] rnk;
        int                len;
        int                n_frames_grp;

        // Synchronous reset, released at a falling edge.
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ---------------- directed part ----------------
        // Rank zero: nothing taken, threshold 255.
        write_rank('0);
        send_pixel(8'd255, 1'b1);
        wait_levels_done();

        // Rank one: a lone dark pixel makes the walk run out of bins (clamp
        // to 0); a lone bright pixel stops right away; repeated bin hits the
        // RAM forward path.
        write_rank(23'd1);
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd128, 1'b0);
        send_pixel(8'd128, 1'b1);
        wait_levels_done();

        // Rank used up exactly at a bin, and one that goes negative.
        write_rank(23'd3);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd200, 1'b0);
        send_pixel(8'd10, 1'b0);
        send_pixel(8'd255, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd0, 1'b1);
        wait_levels_done();

        // Largest rank: exceeds every frame, always clamps to 0.
        write_rank(RANK_MAX);
        send_pixel(8'd0, 1'b0);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd7, 1'b0);
        send_pixel(8'd7, 1'b1);
        wait_levels_done();

        // ---------------- random part ----------------
        // Three idling mixes: sink-heavy stalls, source-heavy gaps, none.
        for (int mix = 0; mix < 3; mix++) begin
            case (mix)
                0: begin src_idle_pct = 31; dst_idle_pct = 52; end
                1: begin src_idle_pct = 52; dst_idle_pct = 31; end
                default: begin src_idle_pct = 0; dst_idle_pct = 0; end
            endcase
            while (n_sent < 19 + (mix + 1) * ITEMS_PER_MIX) begin
                case ($urandom_range(9))
                    0: rnk = '0;
                    1: rnk = RANK_MAX;
                    2: rnk = 23'd1;
                    3: rnk = RANK_W'($urandom_range(RANK_MAX));
                    default: rnk = RANK_W'($urandom_range(48, 2));
                endcase
                write_rank(rnk);
                n_frames_grp = $urandom_range(4, 2);
                for (int f = 0; f < n_frames_grp; f++) begin
                    // Mostly short frames; an occasional long one.
                    if ($urandom_range(15) == 0)
                        len = $urandom_range(160, 64);
                    else
                        len = $urandom_range(16, 1);
                    send_frame(len, t_spread'($urandom_range(3)));
                end
                // Frames of a group may queue behind a stalled result; this
                // drains them all before the next rank write.
                wait_levels_done();
            end
        end

        // Quiet tail: any stray result would show up here.
        pix_if.valid <= 1'b0;
        repeat (300) @(negedge i_clk);

        $display("Covered %0d pixels in %0d frames over %0d rank writes, three idling mixes.",
                 sb.n_pixels, sb.n_frames, sb.n_ranks);
        $display("Compared %0d threshold results.", sb.n_levels);
        if (sb.n_errors == 0 && sb.pending_levels.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
